// File: sv/mbk_pkg.sv
// Shared types, constants and the character pattern table for the Morse buzzer keyer.
// No dependencies; imported by morse_buzzer_keyer.
`default_nettype none

package mbk_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_ELEMENTS_DEF = 6;
  localparam int COUNT_WIDTH_DEF  = 16;

  // Fixed field widths.
  localparam int ACTION_W   = 2;
  localparam int CHAR_W     = 7;
  localparam int DOT_W      = 12;
  localparam int UNIT_W     = 3;
  localparam int PROD_W     = UNIT_W + DOT_W;
  localparam int ELEM_W     = 3;
  localparam int ROM_SLOTS  = 8;
  localparam int ROM_CODE_W = ELEM_W * ROM_SLOTS;
  localparam int ROM_LEN_W  = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DOT_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DOT_TICKS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [DOT_W-1:0] DOT_TICKS_RST   = 12'd100;
  localparam logic             ACTIVE_HIGH_RST = 1'b1;

  // Extra off units after the last element of a character.
  localparam logic [UNIT_W-1:0] CHAR_GAP_UNITS = 3'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_OFFER  = 2'd1,
    ACT_CANCEL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BUZZ = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  // Element codes: dot, dot followed by a wide space, dash, long dash, zero, space.
  typedef enum logic [ELEM_W-1:0] {
    E_DOT  = 3'd0,
    E_DSP  = 3'd1,
    E_DASH = 3'd2,
    E_LONG = 3'd3,
    E_ZERO = 3'd4,
    E_SPC  = 3'd5
  } elem_t;

  typedef struct packed {
    logic                  valid;
    logic [ROM_LEN_W-1:0]  len;
    logic [ROM_CODE_W-1:0] codes;
  } rom_entry_t;

  function automatic logic [UNIT_W-1:0] on_units(input logic [ELEM_W-1:0] code);
    logic [UNIT_W-1:0] u;
    case (code)
      E_DOT:   u = 3'd1;
      E_DSP:   u = 3'd1;
      E_DASH:  u = 3'd2;
      E_LONG:  u = 3'd4;
      E_ZERO:  u = 3'd5;
      E_SPC:   u = 3'd0;
      default: u = 3'd2;
    endcase
    return u;
  endfunction

  function automatic logic [UNIT_W-1:0] off_units(input logic [ELEM_W-1:0] code);
    logic [UNIT_W-1:0] u;
    case (code)
      E_DSP:   u = 3'd2;
      E_SPC:   u = 3'd4;
      default: u = 3'd1;
    endcase
    return u;
  endfunction

  // Builds one table entry; the first element lands in the lowest bits.
  function automatic rom_entry_t ent(input logic [ROM_LEN_W-1:0] n,
                                     input elem_t a, input elem_t b, input elem_t c,
                                     input elem_t d, input elem_t e, input elem_t f);
    rom_entry_t r;
    r.valid = 1'b1;
    r.len   = n;
    r.codes = {E_DOT, E_DOT, f, e, d, c, b, a};
    return r;
  endfunction

  // Pattern table. Codes without an entry, lowercase included, come back invalid.
  // Underscore elements are stored as dashes.
  function automatic rom_entry_t pattern_lookup(input logic [CHAR_W-1:0] ch);
    rom_entry_t r;
    case (ch)
      7'h20: r = ent(4'd1, E_SPC,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // space
      7'h41: r = ent(4'd2, E_DOT,  E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT);  // A
      7'h42: r = ent(4'd4, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // B
      7'h43: r = ent(4'd3, E_DOT,  E_DSP,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // C
      7'h44: r = ent(4'd3, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // D
      7'h45: r = ent(4'd1, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // E
      7'h46: r = ent(4'd3, E_DOT,  E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT);  // F
      7'h47: r = ent(4'd3, E_DASH, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT);  // G
      7'h48: r = ent(4'd4, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // H
      7'h49: r = ent(4'd2, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // I
      7'h4A: r = ent(4'd4, E_DASH, E_DOT,  E_DASH, E_DOT,  E_DOT,  E_DOT);  // J
      7'h4B: r = ent(4'd3, E_DASH, E_DOT,  E_DASH, E_DOT,  E_DOT,  E_DOT);  // K
      7'h4C: r = ent(4'd1, E_LONG, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // L
      7'h4D: r = ent(4'd2, E_DASH, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT);  // M
      7'h4E: r = ent(4'd2, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // N
      7'h4F: r = ent(4'd2, E_DSP,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // O
      7'h50: r = ent(4'd5, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // P
      7'h51: r = ent(4'd4, E_DOT,  E_DOT,  E_DASH, E_DOT,  E_DOT,  E_DOT);  // Q
      7'h52: r = ent(4'd3, E_DSP,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // R
      7'h53: r = ent(4'd3, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // S
      7'h54: r = ent(4'd1, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // T
      7'h55: r = ent(4'd3, E_DOT,  E_DOT,  E_DASH, E_DOT,  E_DOT,  E_DOT);  // U
      7'h56: r = ent(4'd4, E_DOT,  E_DOT,  E_DOT,  E_DASH, E_DOT,  E_DOT);  // V
      7'h57: r = ent(4'd3, E_DOT,  E_DASH, E_DASH, E_DOT,  E_DOT,  E_DOT);  // W
      7'h58: r = ent(4'd4, E_DOT,  E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT);  // X
      7'h59: r = ent(4'd4, E_DOT,  E_DSP,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // Y
      7'h5A: r = ent(4'd4, E_DOT,  E_DOT,  E_DSP,  E_DOT,  E_DOT,  E_DOT);  // Z
      7'h30: r = ent(4'd1, E_ZERO, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // 0
      7'h31: r = ent(4'd4, E_DOT,  E_DASH, E_DASH, E_DOT,  E_DOT,  E_DOT);  // 1
      7'h32: r = ent(4'd5, E_DOT,  E_DOT,  E_DASH, E_DOT,  E_DOT,  E_DOT);  // 2
      7'h33: r = ent(4'd5, E_DOT,  E_DOT,  E_DOT,  E_DASH, E_DOT,  E_DOT);  // 3
      7'h34: r = ent(4'd5, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DASH, E_DOT);  // 4
      7'h35: r = ent(4'd3, E_DASH, E_DASH, E_DASH, E_DOT,  E_DOT,  E_DOT);  // 5
      7'h36: r = ent(4'd6, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // 6
      7'h37: r = ent(4'd4, E_DASH, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT);  // 7
      7'h38: r = ent(4'd5, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // 8
      7'h39: r = ent(4'd4, E_DASH, E_DOT,  E_DOT,  E_DASH, E_DOT,  E_DOT);  // 9
      7'h2E: r = ent(4'd6, E_DOT,  E_DOT,  E_DASH, E_DASH, E_DOT,  E_DOT);  // period
      7'h2C: r = ent(4'd4, E_DOT,  E_DASH, E_DOT,  E_DASH, E_DOT,  E_DOT);  // comma
      7'h3F: r = ent(4'd5, E_DASH, E_DOT,  E_DOT,  E_DASH, E_DOT,  E_DOT);  // question
      7'h27: r = ent(4'd6, E_DOT,  E_DASH, E_DASH, E_DASH, E_DASH, E_DOT);  // apostrophe
      7'h21: r = ent(4'd4, E_DASH, E_DASH, E_DASH, E_DOT,  E_DOT,  E_DOT);  // exclamation
      7'h2F: r = ent(4'd5, E_DASH, E_DOT,  E_DOT,  E_DASH, E_DOT,  E_DOT);  // slash
      7'h28: r = ent(4'd6, E_DASH, E_DOT,  E_DASH, E_DASH, E_DOT,  E_DASH); // open paren
      7'h29: r = ent(4'd6, E_DASH, E_DOT,  E_DASH, E_DASH, E_DOT,  E_DASH); // close paren
      7'h26: r = ent(4'd4, E_DSP,  E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DOT);  // ampersand
      7'h3A: r = ent(4'd6, E_DASH, E_DASH, E_DASH, E_DOT,  E_DOT,  E_DOT);  // colon
      7'h3B: r = ent(4'd6, E_DASH, E_DOT,  E_DASH, E_DOT,  E_DASH, E_DOT);  // semicolon
      7'h3D: r = ent(4'd5, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DASH, E_DOT);  // equals
      7'h2D: r = ent(4'd6, E_DASH, E_DOT,  E_DOT,  E_DOT,  E_DOT,  E_DASH); // hyphen
      7'h5F: r = ent(4'd6, E_DOT,  E_DOT,  E_DASH, E_DASH, E_DOT,  E_DASH); // underscore
      7'h22: r = ent(4'd6, E_DOT,  E_DASH, E_DOT,  E_DOT,  E_DASH, E_DOT);  // quote
      7'h40: r = ent(4'd6, E_DOT,  E_DASH, E_DASH, E_DOT,  E_DASH, E_DOT);  // at sign
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/morse_buzzer_keyer.sv
// Top level of the Morse buzzer keyer: request handshakes, configuration registers,
// element timing state and the registered result. Depends on mbk_pkg.
`default_nettype none

// The keyer drives a buzzer with American-style Morse, one character at a time. Every
// input request carries an action: a tick (one unit of time passes), a character offer,
// or a cancel. Each request produces exactly one result that reports the buzzer pin
// level after the request, whether a character is still playing, and whether an offered
// character was taken. A character is taken only while idle and only if the pattern
// table holds an entry for it; lowercase letters and other unlisted codes are skipped.
// Elements are timed in multiples of dot_ticks ticks, and the last element of each
// character is followed by three more off units. The block handles one request per
// clock: the whole step (table lookup, small unit-times-dot_ticks products, one counter
// compare) sits between the accepted request and the result register, and a new request
// is taken in the same cycle that the previous result is taken, so a stalled output side
// holds the input side for as long as the result waits. Configuration writes are always
// ready and take effect on the next request; dot_ticks applies from the next element on.
module morse_buzzer_keyer #(
  parameter int MAX_ELEMENTS = mbk_pkg::MAX_ELEMENTS_DEF,
  parameter int COUNT_WIDTH  = mbk_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input requests. in_tdata: [1:0] action, [8:2] char_code, [15:9] zero.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mbk_pkg::IN_DATA_W-1:0]   in_tdata,
  // Results. out_tdata: [0] buzzer_level, [1] playing, [2] accepted, [7:3] zero.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mbk_pkg::OUT_DATA_W-1:0]       out_tdata,
  // Configuration writes: index 0 dot_ticks, index 1 active_high (bit 0).
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mbk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mbk_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mbk_pkg::*;

  localparam int CODES_W = ELEM_W * MAX_ELEMENTS;
  localparam int LEFT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int LEN_W   = (COUNT_WIDTH > PROD_W) ? COUNT_WIDTH : PROD_W;

  // Configuration registers.
  logic [DOT_W-1:0]       dot_ticks_r;
  logic                   active_high_r;

  // Keyer state.
  phase_t                 phase_r, phase_nxt;
  logic [CODES_W-1:0]     codes_r, codes_nxt;
  logic [LEFT_W-1:0]      left_r, left_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0] on_len_r, on_len_nxt;
  logic [COUNT_WIDTH-1:0] off_len_r, off_len_nxt;
  logic                   sounding_r, sounding_nxt;

  // Result register.
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [OUT_DATA_W-1:0]  out_data_nxt;

  // Request fields and helpers.
  logic                   in_accept;
  logic [ACTION_W-1:0]    req_action;
  logic [CHAR_W-1:0]      req_char;
  rom_entry_t             rom_ent;
  logic [ROM_CODE_W-1:0]  rom_codes_ext;
  logic [LEFT_W-1:0]      rom_left;

  // Element loader: source of the next element and the lengths it gets.
  logic [CODES_W-1:0]     src_codes;
  logic [LEFT_W-1:0]      src_left;
  logic [ELEM_W-1:0]      ld_code;
  logic [LEFT_W-1:0]      ld_left;
  logic [UNIT_W-1:0]      ld_on_units;
  logic [UNIT_W-1:0]      ld_off_units;
  logic [COUNT_WIDTH-1:0] ld_on_len;
  logic [COUNT_WIDTH-1:0] ld_off_len;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic                   accepted;

  // Units times dot_ticks, saturated to the counter width.
  function automatic logic [COUNT_WIDTH-1:0] sat_len(input logic [UNIT_W-1:0] units,
                                                     input logic [DOT_W-1:0] dot);
    logic [PROD_W-1:0] prod;
    logic [LEN_W-1:0]  prod_ext;
    logic [COUNT_WIDTH-1:0] res;
    prod     = PROD_W'(units) * PROD_W'(dot);
    prod_ext = LEN_W'(prod);
    if ((prod_ext >> COUNT_WIDTH) != '0) begin
      res = '1;
    end else begin
      res = prod_ext[COUNT_WIDTH-1:0];
    end
    return res;
  endfunction

  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  assign req_action = in_tdata[ACTION_W-1:0];
  assign req_char   = in_tdata[ACTION_W +: CHAR_W];

  // Pattern table lookup, trimmed to the number of elements the block holds.
  assign rom_ent       = pattern_lookup(req_char);
  assign rom_codes_ext = rom_ent.codes;
  assign rom_left      = ({1'b0, rom_ent.len} > (ROM_LEN_W + 1)'(MAX_ELEMENTS))
                         ? LEFT_W'(MAX_ELEMENTS) : LEFT_W'(rom_ent.len);

  // An offer loads its first element straight from the table; a tick loads from state.
  always_comb begin
    if (req_action == ACT_OFFER) begin
      src_codes = rom_codes_ext[CODES_W-1:0];
      src_left  = rom_left;
    end else begin
      src_codes = codes_r;
      src_left  = left_r;
    end
    ld_code      = src_codes[ELEM_W-1:0];
    ld_left      = (src_left != '0) ? LEFT_W'(src_left - 1'b1) : '0;
    ld_on_units  = on_units(ld_code);
    ld_off_units = off_units(ld_code);
    if (ld_left == '0) begin
      ld_off_units = UNIT_W'(ld_off_units + CHAR_GAP_UNITS);
    end
    ld_on_len  = sat_len(ld_on_units, dot_ticks_r);
    ld_off_len = sat_len(ld_off_units, dot_ticks_r);
  end

  assign tick_inc = (tick_r == '1) ? tick_r : COUNT_WIDTH'(tick_r + 1'b1);

  // Next state and result for the request at the input.
  always_comb begin
    phase_nxt    = phase_r;
    codes_nxt    = codes_r;
    left_nxt     = left_r;
    tick_nxt     = tick_r;
    on_len_nxt   = on_len_r;
    off_len_nxt  = off_len_r;
    sounding_nxt = sounding_r;
    accepted     = 1'b0;

    case (req_action)
      ACT_TICK: begin
        case (phase_r)
          PH_BUZZ: begin
            if (tick_inc >= on_len_r) begin
              phase_nxt    = PH_GAP;
              sounding_nxt = 1'b0;
              tick_nxt     = '0;
            end else begin
              tick_nxt = tick_inc;
            end
          end
          PH_GAP: begin
            tick_nxt = tick_inc;
            if (tick_inc >= off_len_r) begin
              if (left_r != '0) begin
                codes_nxt    = src_codes >> ELEM_W;
                left_nxt     = ld_left;
                on_len_nxt   = ld_on_len;
                off_len_nxt  = ld_off_len;
                tick_nxt     = '0;
                phase_nxt    = (ld_on_len != '0) ? PH_BUZZ : PH_GAP;
                sounding_nxt = (ld_on_len != '0);
              end else begin
                phase_nxt    = PH_IDLE;
                sounding_nxt = 1'b0;
              end
            end
          end
          default: begin
            // Idle: a tick changes nothing.
          end
        endcase
      end
      ACT_OFFER: begin
        if (phase_r == PH_IDLE && rom_ent.valid) begin
          accepted     = 1'b1;
          codes_nxt    = src_codes >> ELEM_W;
          left_nxt     = ld_left;
          on_len_nxt   = ld_on_len;
          off_len_nxt  = ld_off_len;
          tick_nxt     = '0;
          phase_nxt    = (ld_on_len != '0) ? PH_BUZZ : PH_GAP;
          sounding_nxt = (ld_on_len != '0);
        end
      end
      ACT_CANCEL: begin
        phase_nxt    = PH_IDLE;
        sounding_nxt = 1'b0;
        left_nxt     = '0;
        codes_nxt    = '0;
        tick_nxt     = '0;
      end
      default: begin
        // Unused action code: the result only reports the present state.
      end
    endcase

    out_data_nxt    = '0;
    out_data_nxt[0] = sounding_nxt ? active_high_r : !active_high_r;
    out_data_nxt[1] = (phase_nxt != PH_IDLE);
    out_data_nxt[2] = accepted;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_ticks_r   <= DOT_TICKS_RST;
      active_high_r <= ACTIVE_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DOT_TICKS:   dot_ticks_r   <= cfg_data[DOT_W-1:0];
        CFG_ACTIVE_HIGH: active_high_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Keyer state advances only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      codes_r    <= '0;
      left_r     <= '0;
      tick_r     <= '0;
      on_len_r   <= '0;
      off_len_r  <= '0;
      sounding_r <= 1'b0;
    end else if (in_accept) begin
      phase_r    <= phase_nxt;
      codes_r    <= codes_nxt;
      left_r     <= left_nxt;
      tick_r     <= tick_nxt;
      on_len_r   <= on_len_nxt;
      off_len_r  <= off_len_nxt;
      sounding_r <= sounding_nxt;
    end
  end

  // Result register: loads with each accepted request, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for morse_buzzer_keyer: a directed table and random request
// streams under sender bursts, receiver stalls and several register settings.
// Depends on mbk_pkg and morse_buzzer_keyer.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbk_pkg::*;

  // Action code the block does not define; it must leave the state alone.
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

  localparam int          ELEMENTS_MAX = MAX_ELEMENTS_DEF;
  localparam int unsigned LENGTH_MAX   = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          NUM_SETTINGS = 7;

  // Expected pin state after one request.
  typedef struct packed {
    logic buzz;
    logic playing;
    logic taken;
  } keyer_result_t;

  // One row of the directed table. When typed is set, want holds the expected
  // result as read off the timing rules; otherwise the predictor supplies it.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   code;
    logic                typed;
    keyer_result_t       want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  morse_buzzer_keyer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Keyer predictor. It mirrors the block's registers and timing state and is
  // advanced once for every request the block accepts, in acceptance order.
  // ---------------------------------------------------------------------------
  phase_t                       key_phase    = PH_IDLE;
  logic [ELEM_W*ELEMENTS_MAX-1:0] key_codes  = '0;
  int unsigned                  key_left     = 0;
  int unsigned                  key_ticks    = 0;
  int unsigned                  key_on_len   = 0;
  int unsigned                  key_off_len  = 0;
  logic                         key_sounding = 1'b0;
  logic [DOT_W-1:0]             key_dot      = DOT_TICKS_RST;
  logic                         key_polarity = ACTIVE_HIGH_RST;

  // Dot/dash pattern of each character the keyer knows; empty means no entry.
  function automatic string char_pattern(input logic [CHAR_W-1:0] code);
    case ({1'b0, code})
      " ": return " ";
      "A": return ".-";     "B": return "-...";   "C": return ".,.";    "D": return "-..";
      "E": return ".";      "F": return ".-.";    "G": return "--.";    "H": return "....";
      "I": return "..";     "J": return "-.-.";   "K": return "-.-";    "L": return "L";
      "M": return "--";     "N": return "-.";     "O": return ",.";     "P": return ".....";
      "Q": return "..-.";   "R": return ",..";    "S": return "...";    "T": return "-";
      "U": return "..-";    "V": return "...-";   "W": return ".--";    "X": return ".-..";
      "Y": return ".,..";   "Z": return "..,.";
      "0": return "0";      "1": return ".--.";   "2": return "..-..";  "3": return "...-.";
      "4": return "....-";  "5": return "---";    "6": return "......"; "7": return "--..";
      "8": return "-....";  "9": return "-..-";
      ".": return "..--.."; ",": return ".-.-";   "?": return "-..-.";  "'": return ".----.";
      "!": return "---.";   "/": return "-..-.";  "(": return "-.--.-"; ")": return "-.--.-";
      "&": return ",...";   ":": return "---..."; ";": return "-.-.-."; "=": return "-...-";
      "-": return "-....-"; "_": return "..__._"; "\"": return ".-..-."; "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  // Underscores and any other unlisted symbol play as a dash.
  function automatic elem_t element_of(input byte symbol);
    case (symbol)
      ".":     return E_DOT;
      ",":     return E_DSP;
      "L":     return E_LONG;
      "0":     return E_ZERO;
      " ":     return E_SPC;
      default: return E_DASH;
    endcase
  endfunction

  function automatic int unsigned element_on_units(input elem_t e);
    case (e)
      E_DOT, E_DSP: return 1;
      E_LONG:       return 4;
      E_ZERO:       return 5;
      E_SPC:        return 0;
      default:      return 2;
    endcase
  endfunction

  function automatic int unsigned element_off_units(input elem_t e);
    case (e)
      E_DSP:   return 2;
      E_SPC:   return 4;
      default: return 1;
    endcase
  endfunction

  function automatic int unsigned scaled_length(input int unsigned units);
    int unsigned ticks;
    ticks = units * key_dot;
    return (ticks > LENGTH_MAX) ? LENGTH_MAX : ticks;
  endfunction

  // Pops the next element and starts its on phase, or its gap when it has no on time.
  function automatic void start_next_element();
    elem_t       e;
    int unsigned off_units;
    e = elem_t'(key_codes[ELEM_W-1:0]);
    key_codes = key_codes >> ELEM_W;
    if (key_left > 0) key_left--;
    off_units = element_off_units(e) + ((key_left == 0) ? CHAR_GAP_UNITS : 0);
    key_on_len  = scaled_length(element_on_units(e));
    key_off_len = scaled_length(off_units);
    key_ticks   = 0;
    if (key_on_len > 0) begin
      key_phase    = PH_BUZZ;
      key_sounding = 1'b1;
    end else begin
      key_phase    = PH_GAP;
      key_sounding = 1'b0;
    end
  endfunction

  function automatic keyer_result_t key_one_request(input logic [ACTION_W-1:0] action,
                                                    input logic [CHAR_W-1:0]   code);
    keyer_result_t r;
    string         pat;
    int            n;
    r.taken = 1'b0;
    case (action)
      ACT_TICK: begin
        if (key_phase != PH_IDLE) begin
          if (key_ticks < LENGTH_MAX) key_ticks++;
          if (key_phase == PH_BUZZ) begin
            if (key_ticks >= key_on_len) begin
              key_sounding = 1'b0;
              key_phase    = PH_GAP;
              key_ticks    = 0;
            end
          end else if (key_ticks >= key_off_len) begin
            if (key_left > 0) begin
              start_next_element();
            end else begin
              key_phase    = PH_IDLE;
              key_sounding = 1'b0;
            end
          end
        end
      end
      ACT_OFFER: begin
        pat = char_pattern(code);
        if (key_phase == PH_IDLE && pat.len() > 0) begin
          key_codes = '0;
          n = 0;
          while (n < ELEMENTS_MAX && n < pat.len()) begin
            key_codes = key_codes |
                        ((ELEM_W*ELEMENTS_MAX)'(element_of(pat[n])) << (ELEM_W * n));
            n++;
          end
          key_left = n;
          r.taken  = 1'b1;
          start_next_element();
        end
      end
      ACT_CANCEL: begin
        key_phase    = PH_IDLE;
        key_sounding = 1'b0;
        key_left     = 0;
        key_codes    = '0;
        key_ticks    = 0;
      end
      default: begin
      end
    endcase
    r.buzz    = key_sounding ? key_polarity : ~key_polarity;
    r.playing = (key_phase != PH_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Expected pin states wait in acceptance order; every result
  // the block hands over is compared with the oldest one.
  // ---------------------------------------------------------------------------
  keyer_result_t pending_pins [$];
  int mismatches  = 0;
  int results_seen = 0;
  int cycle_count = 0;

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    keyer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_pins.size() == 0) begin
        report_mismatch("unrequested result (tdata)", -1, int'(out_tdata));
      end else begin
        want = pending_pins.pop_front();
        if (out_tdata[0] !== want.buzz)
          report_mismatch("buzzer_level", int'(want.buzz), int'(out_tdata[0]));
        if (out_tdata[1] !== want.playing)
          report_mismatch("playing", int'(want.playing), int'(out_tdata[1]));
        if (out_tdata[2] !== want.taken)
          report_mismatch("accepted", int'(want.taken), int'(out_tdata[2]));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Receiver backpressure: spans of always ready, random stalls, and a slow
  // one-in-four pattern, each lasting a random number of cycles.
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(16, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 9) < 6);
      default: out_tready <= (stall_span[1:0] == 2'd0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  // Directed table, all at the reset settings (100 ticks per dot, active high).
  // Expected bits are buzzer, playing, accepted.
  directed_row_t directed_rows [25] = '{
    {ACT_TICK,     7'h00, 1'b1, 3'b000},  // tick while idle
    {ACT_CANCEL,   7'h00, 1'b1, 3'b000},  // cancel while idle
    {ACT_RESERVED, 7'h7F, 1'b1, 3'b000},  // undefined action while idle
    {ACT_OFFER,    7'h61, 1'b1, 3'b000},  // lowercase 'a' has no pattern
    {ACT_OFFER,    7'h7F, 1'b1, 3'b000},  // highest code, no pattern
    {ACT_OFFER,    7'h00, 1'b1, 3'b000},  // lowest code, no pattern
    {ACT_OFFER,    7'h45, 1'b1, 3'b111},  // 'E' starts a dot
    {ACT_OFFER,    7'h54, 1'b1, 3'b110},  // offer while playing is refused
    {ACT_TICK,     7'h00, 1'b1, 3'b110},  // first tick of a long dot
    {ACT_RESERVED, 7'h00, 1'b1, 3'b110},  // undefined action while buzzing
    {ACT_CANCEL,   7'h00, 1'b1, 3'b000},
    {ACT_OFFER,    7'h20, 1'b1, 3'b011},  // space starts silent, straight in its gap
    {ACT_TICK,     7'h00, 1'b0, 3'b000},
    {ACT_CANCEL,   7'h00, 1'b1, 3'b000},
    {ACT_OFFER,    7'h5F, 1'b1, 3'b111},  // underscore, dashes stand in for '_'
    {ACT_CANCEL,   7'h00, 1'b1, 3'b000},
    {ACT_OFFER,    7'h4C, 1'b1, 3'b111},  // 'L', the long dash
    {ACT_CANCEL,   7'h00, 1'b1, 3'b000},
    {ACT_OFFER,    7'h30, 1'b1, 3'b111},  // '0', the longest element
    {ACT_CANCEL,   7'h00, 1'b1, 3'b000},
    {ACT_OFFER,    7'h43, 1'b0, 3'b000},  // 'C' has a spaced dot
    {ACT_OFFER,    7'h28, 1'b0, 3'b000},  // refused, still busy with 'C'
    {ACT_CANCEL,   7'h00, 1'b1, 3'b000},
    {ACT_OFFER,    7'h28, 1'b0, 3'b000},  // six-element pattern
    {ACT_CANCEL,   7'h00, 1'b1, 3'b000}
  };

  // Register settings walked by the random part; a zero dot length is included
  // since it turns every element into a bare gap.
  int unsigned setting_dot   [NUM_SETTINGS] = '{1, 2, 0, 3, 4095, 1, 7};
  logic        setting_pol   [NUM_SETTINGS] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
  int unsigned setting_items [NUM_SETTINGS] = '{300, 250, 100, 200, 60, 200, 100};

  string known_chars = " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=-_\"@";

  int burst_left    = 0;
  int ticks_sent    = 0;
  int offers_sent   = 0;
  int cancels_sent  = 0;
  int chars_keyed   = 0;

  // The sender works in bursts; between bursts tvalid drops for a random gap,
  // and some bursts follow with no gap at all.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  // Presents one request, waits for the handshake, and files its expected
  // result. busy tells whether the request did anything beyond echoing state.
  task automatic send_request(input logic [ACTION_W-1:0] action, input logic [CHAR_W-1:0] code,
                              input logic typed, input keyer_result_t typed_want,
                              output logic busy);
    keyer_result_t predicted;
    logic          was_playing;
    pace_sender();
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-ACTION_W-CHAR_W){1'b0}}, code, action};
    do @(posedge clk); while (!in_tready);
    was_playing = (key_phase != PH_IDLE);
    predicted = key_one_request(action, code);
    pending_pins.push_back(typed ? typed_want : predicted);
    busy = was_playing || predicted.taken;
    case (action)
      ACT_TICK:   ticks_sent++;
      ACT_OFFER:  offers_sent++;
      ACT_CANCEL: cancels_sent++;
      default: ;
    endcase
    if (predicted.taken) chars_keyed++;
  endtask

  // Holds the sender until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_pins.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [DOT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == CFG_DOT_TICKS) key_dot = value;
    else key_polarity = value[0];
  endtask

  // Random request shaped by the keyer's state: while idle mostly known
  // characters, while playing mostly ticks with the odd cancel or stray offer.
  task automatic pick_request(output logic [ACTION_W-1:0] action, output logic [CHAR_W-1:0] code);
    int roll;
    roll   = $urandom_range(0, 99);
    code   = CHAR_W'($urandom_range(0, 127));
    if (key_phase == PH_IDLE) begin
      if (roll < 60) begin
        action = ACT_OFFER;
        code   = CHAR_W'(known_chars[$urandom_range(0, known_chars.len() - 1)]);
      end else if (roll < 75) action = ACT_OFFER;
      else if (roll < 90)     action = ACT_TICK;
      else if (roll < 95)     action = ACT_CANCEL;
      else                    action = ACT_RESERVED;
    end else begin
      if (roll < 90)      action = ACT_TICK;
      else if (roll < 92) action = ACT_CANCEL;
      else if (roll < 97) action = ACT_OFFER;
      else                action = ACT_RESERVED;
    end
  endtask

  initial begin : stimulus
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   code;
    logic                busy;
    int                  active;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].action, directed_rows[i].code,
                   directed_rows[i].typed, directed_rows[i].want, busy);

    // Each setting is applied only once the keyer has answered everything and
    // the sender has paused, then a random stream runs under it.
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain_results();
      repeat (2) @(posedge clk);
      write_register(CFG_DOT_TICKS, DOT_W'(setting_dot[s]));
      write_register(CFG_ACTIVE_HIGH, DOT_W'(setting_pol[s]));
      cfg_valid <= 1'b0;
      active = 0;
      while (active < setting_items[s]) begin
        pick_request(action, code);
        send_request(action, code, 1'b0, '0, busy);
        if (busy) active++;
        // Once, partway through the first stream, let the output side empty out.
        if (s == 0 && active == setting_items[s] / 2 && busy) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d ticks, %0d offers and %0d cancels; %0d characters were keyed.",
             ticks_sent, offers_sent, cancels_sent, chars_keyed);
    $display("Checked %0d results across %0d register settings plus the reset values.",
             results_seen, NUM_SETTINGS);
    if (mismatches == 0 && pending_pins.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog on the cycle counter.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, pending_pins.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
